// ----- rtl/mqttrd_pkg.sv -----
// Shared types, codes and defaults for the MQTT receive deframer.
// Used by the front, queue, back and top-level modules; depends on nothing.
package mqttrd_pkg;

  localparam int MAX_TOPIC_DEF        = 64;
  localparam int MAX_LENGTH_BYTES_DEF = 4;
  localparam int QUEUE_DEPTH_DEF      = 4;

  localparam logic [3:0] EV_TOPIC       = 4'd0;
  localparam logic [3:0] EV_PAYLOAD     = 4'd1;
  localparam logic [3:0] EV_CONNACK_OK  = 4'd2;
  localparam logic [3:0] EV_CONNACK_REF = 4'd3;
  localparam logic [3:0] EV_SUBACK      = 4'd4;
  localparam logic [3:0] EV_PINGRESP    = 4'd5;
  localparam logic [3:0] EV_UNKNOWN     = 4'd6;
  localparam logic [3:0] EV_PUB_END     = 4'd7;
  localparam logic [3:0] EV_PUB_DROP    = 4'd8;
  localparam logic [3:0] EV_MALFORMED   = 4'd9;

  localparam logic [3:0] PK_CONNACK  = 4'd2;
  localparam logic [3:0] PK_PUBLISH  = 4'd3;
  localparam logic [3:0] PK_SUBACK   = 4'd9;
  localparam logic [3:0] PK_PINGRESP = 4'd13;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] data;
    logic       pkt_end;
  } ev_t;

  typedef struct packed {
    ev_t  first;
    logic two;
    ev_t  second;
  } entry_t;

  typedef struct packed {
    logic valid;
    ev_t  ev;
  } fin_t;

  function automatic fin_t finish_ev(input logic [3:0] pkind, input logic len_ge2,
                                     input logic [7:0] code, input logic kept);
    fin_t f;
    f.valid      = 1'b1;
    f.ev.pkt_end = 1'b1;
    f.ev.data    = 8'h00;
    case (pkind)
      PK_CONNACK: begin
        f.valid   = len_ge2;
        f.ev.kind = (code == 8'h00) ? EV_CONNACK_OK : EV_CONNACK_REF;
        f.ev.data = code;
      end
      PK_SUBACK:   f.ev.kind = EV_SUBACK;
      PK_PINGRESP: f.ev.kind = EV_PINGRESP;
      PK_PUBLISH:  f.ev.kind = kept ? EV_PUB_END : EV_PUB_DROP;
      default: begin
        f.ev.kind = EV_UNKNOWN;
        f.ev.data = {pkind, 4'h0};
      end
    endcase
    return f;
  endfunction

endpackage

// ----- rtl/mqttrd_front.sv -----
// Front parser: takes one received byte per cycle unless q_full, tracks
// packet framing, pushes each byte's results to the queue. Uses mqttrd_pkg.
module mqttrd_front #(
  parameter int MAX_TOPIC        = 64,
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_rx_byte,
  input  logic                q_full,
  output logic                push,
  output mqttrd_pkg::entry_t  push_entry
);
  import mqttrd_pkg::*;

  localparam logic [2:0] PH_HEADER   = 3'd0;
  localparam logic [2:0] PH_LENGTH   = 3'd1;
  localparam logic [2:0] PH_BODY     = 3'd2;
  localparam logic [2:0] PH_TOPIC_HI = 3'd3;
  localparam logic [2:0] PH_TOPIC_LO = 3'd4;
  localparam logic [2:0] PH_TOPIC    = 3'd5;
  localparam logic [2:0] PH_PAYLOAD  = 3'd6;
  localparam logic [2:0] PH_DISCARD  = 3'd7;

  localparam logic [2:0]  MaxLb    = 3'(MAX_LENGTH_BYTES);
  localparam logic [16:0] MaxTopic = 17'(MAX_TOPIC);

  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  kind_r, kind_nxt;
  logic [27:0] accum_r, accum_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [27:0] left_r, left_nxt;
  logic [15:0] topic_r, topic_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic [7:0]  code_r, code_nxt;
  logic        kept_r, kept_nxt;
  logic [1:0]  pos_r, pos_nxt;

  logic        accept;
  logic        emit_data;
  logic [3:0]  data_kind;
  logic        malformed;
  logic        do_finish;
  logic [27:0] shifted;
  logic [27:0] left_dec;
  logic [15:0] tl;
  fin_t        fin;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign left_dec = left_r - 28'd1;
  assign tl       = {hi_r, in_rx_byte};

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    shifted = {21'd0, in_rx_byte[6:0]};
      2'd1:    shifted = {14'd0, in_rx_byte[6:0], 7'd0};
      2'd2:    shifted = {7'd0, in_rx_byte[6:0], 14'd0};
      default: shifted = {in_rx_byte[6:0], 21'd0};
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    accum_nxt = accum_r;
    cnt_nxt   = cnt_r;
    left_nxt  = left_r;
    topic_nxt = topic_r;
    hi_nxt    = hi_r;
    code_nxt  = code_r;
    kept_nxt  = kept_r;
    pos_nxt   = pos_r;
    emit_data = 1'b0;
    data_kind = EV_TOPIC;
    malformed = 1'b0;
    do_finish = 1'b0;
    case (phase_r)
      PH_HEADER: begin
        kind_nxt  = in_rx_byte[7:4];
        accum_nxt = '0;
        cnt_nxt   = '0;
        left_nxt  = '0;
        topic_nxt = '0;
        hi_nxt    = '0;
        code_nxt  = '0;
        kept_nxt  = 1'b0;
        pos_nxt   = '0;
        phase_nxt = PH_LENGTH;
      end
      PH_LENGTH: begin
        accum_nxt = accum_r | shifted;
        cnt_nxt   = cnt_r + 3'd1;
        if (in_rx_byte[7]) begin
          if (cnt_nxt >= MaxLb) begin
            malformed = 1'b1;
            phase_nxt = PH_HEADER;
          end
        end else begin
          left_nxt = accum_nxt;
          if (accum_nxt == 28'd0) begin
            do_finish = 1'b1;
            phase_nxt = PH_HEADER;
          end else begin
            phase_nxt = (kind_r == PK_PUBLISH) ? PH_TOPIC_HI : PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (kind_r == PK_CONNACK && pos_r == 2'd1) begin
          code_nxt = in_rx_byte;
        end
        pos_nxt  = (pos_r == 2'd2) ? pos_r : pos_r + 2'd1;
        left_nxt = left_dec;
        if (left_dec == 28'd0) begin
          do_finish = 1'b1;
          phase_nxt = PH_HEADER;
        end
      end
      PH_TOPIC_HI: begin
        hi_nxt   = in_rx_byte;
        left_nxt = left_dec;
        if (left_dec == 28'd0) begin
          do_finish = 1'b1;
          phase_nxt = PH_HEADER;
        end else begin
          phase_nxt = PH_TOPIC_LO;
        end
      end
      PH_TOPIC_LO: begin
        left_nxt = left_dec;
        if ({1'b0, tl} >= MaxTopic || {12'd0, tl} > left_dec) begin
          kept_nxt = 1'b0;
          if (left_dec == 28'd0) begin
            do_finish = 1'b1;
            phase_nxt = PH_HEADER;
          end else begin
            phase_nxt = PH_DISCARD;
          end
        end else begin
          kept_nxt  = 1'b1;
          topic_nxt = tl;
          if (left_dec == 28'd0) begin
            do_finish = 1'b1;
            phase_nxt = PH_HEADER;
          end else begin
            phase_nxt = (tl != 16'd0) ? PH_TOPIC : PH_PAYLOAD;
          end
        end
      end
      PH_TOPIC: begin
        emit_data = 1'b1;
        data_kind = EV_TOPIC;
        topic_nxt = topic_r - 16'd1;
        left_nxt  = left_dec;
        if (left_dec == 28'd0) begin
          do_finish = 1'b1;
          phase_nxt = PH_HEADER;
        end else if (topic_nxt == 16'd0) begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        emit_data = 1'b1;
        data_kind = EV_PAYLOAD;
        left_nxt  = left_dec;
        if (left_dec == 28'd0) begin
          do_finish = 1'b1;
          phase_nxt = PH_HEADER;
        end
      end
      PH_DISCARD: begin
        left_nxt = left_dec;
        if (left_dec == 28'd0) begin
          do_finish = 1'b1;
          phase_nxt = PH_HEADER;
        end
      end
      default: phase_nxt = PH_HEADER;
    endcase
  end

  assign fin = finish_ev(kind_r, accum_nxt >= 28'd2, code_nxt, kept_nxt);

  always_comb begin
    push_entry.first         = fin.ev;
    push_entry.two           = 1'b0;
    push_entry.second        = fin.ev;
    if (emit_data) begin
      push_entry.first.kind    = data_kind;
      push_entry.first.data    = in_rx_byte;
      push_entry.first.pkt_end = 1'b0;
      push_entry.two           = do_finish && fin.valid;
    end else if (malformed) begin
      push_entry.first.kind    = EV_MALFORMED;
      push_entry.first.data    = 8'h00;
      push_entry.first.pkt_end = 1'b1;
    end
  end

  assign push = accept && (emit_data || malformed || (do_finish && fin.valid));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      kind_r  <= '0;
      accum_r <= '0;
      cnt_r   <= '0;
      left_r  <= '0;
      topic_r <= '0;
      hi_r    <= '0;
      code_r  <= '0;
      kept_r  <= 1'b0;
      pos_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      accum_r <= accum_nxt;
      cnt_r   <= cnt_nxt;
      left_r  <= left_nxt;
      topic_r <= topic_nxt;
      hi_r    <= hi_nxt;
      code_r  <= code_nxt;
      kept_r  <= kept_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

// ----- rtl/mqttrd_queue.sv -----
// Short FIFO of per-byte result entries between the front parser and the
// output stage. Depends on mqttrd_pkg.
module mqttrd_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mqttrd_pkg::entry_t  push_entry,
  output logic                full,
  input  logic                pop,
  output logic                nonempty,
  output mqttrd_pkg::entry_t  head
);
  import mqttrd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);
  localparam logic [CW-1:0] Depth   = CW'(DEPTH);

  entry_t          mem_r [DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt;
  logic [PW-1:0]   rd_r, rd_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_pop;

  assign full     = (cnt_r == Depth);
  assign nonempty = (cnt_r != '0);
  assign head     = mem_r[rd_r];
  assign do_pop   = pop && nonempty;

  always_comb begin
    wr_nxt  = push ? ((wr_r == LastPtr) ? '0 : wr_r + PW'(1)) : wr_r;
    rd_nxt  = do_pop ? ((rd_r == LastPtr) ? '0 : rd_r + PW'(1)) : rd_r;
    cnt_nxt = cnt_r + CW'(push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/mqttrd_back.sv -----
// Output stage: takes queue entries and delivers their one or two results
// through a registered valid/stall port. Depends on mqttrd_pkg.
module mqttrd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_nonempty,
  input  mqttrd_pkg::entry_t  q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [3:0]          out_event_kind,
  output logic [7:0]          out_data_byte,
  output logic                out_packet_end
);
  import mqttrd_pkg::*;

  logic valid_r, valid_nxt;
  ev_t  ev_r, ev_nxt;
  logic pend_r, pend_nxt;
  ev_t  pend_ev_r, pend_ev_nxt;
  logic advance;

  assign advance = !valid_r || !out_stall;
  assign q_pop   = advance && !pend_r && q_nonempty;

  always_comb begin
    valid_nxt   = valid_r;
    ev_nxt      = ev_r;
    pend_nxt    = pend_r;
    pend_ev_nxt = pend_ev_r;
    if (advance) begin
      if (pend_r) begin
        valid_nxt = 1'b1;
        ev_nxt    = pend_ev_r;
        pend_nxt  = 1'b0;
      end else if (q_nonempty) begin
        valid_nxt   = 1'b1;
        ev_nxt      = q_head.first;
        pend_nxt    = q_head.two;
        pend_ev_nxt = q_head.second;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_r      <= ev_nxt;
    pend_ev_r <= pend_ev_nxt;
  end

  assign out_valid      = valid_r;
  assign out_event_kind = ev_r.kind;
  assign out_data_byte  = ev_r.data;
  assign out_packet_end = ev_r.pkt_end;

endmodule

// ----- rtl/mqtt_receive_deframer.sv -----
// Top level of the MQTT receive deframer: front parser, entry queue, output stage.
// Depends on mqttrd_pkg, mqttrd_front, mqttrd_queue and mqttrd_back.
//
// The block accepts one received byte per clock cycle unless stalled and reports
// topic and payload bytes of kept PUBLISH packets and one event at the end of every
// packet but a CONNACK shorter than two bytes. Each byte is parsed in the cycle it
// is accepted; its results pass through the entry queue and the output register. A
// topic or payload byte that ends a packet yields two results, which leave the
// output register in turn; the QUEUE_DEPTH entry queue absorbs that, so input
// stalls only when it fills because the output is stalled or such bytes run long.
module mqtt_receive_deframer #(
  parameter int MAX_TOPIC        = mqttrd_pkg::MAX_TOPIC_DEF,
  parameter int MAX_LENGTH_BYTES = mqttrd_pkg::MAX_LENGTH_BYTES_DEF,
  parameter int QUEUE_DEPTH      = mqttrd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_event_kind,
  output logic [7:0] out_data_byte,
  output logic       out_packet_end
);
  import mqttrd_pkg::*;

  logic   q_full;
  logic   push;
  entry_t push_entry;
  logic   q_pop;
  logic   q_nonempty;
  entry_t q_head;

  mqttrd_front #(
    .MAX_TOPIC       (MAX_TOPIC),
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_rx_byte(in_rx_byte),
    .q_full    (q_full),
    .push      (push),
    .push_entry(push_entry)
  );

  mqttrd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  mqttrd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_nonempty    (q_nonempty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_event_kind(out_event_kind),
    .out_data_byte (out_data_byte),
    .out_packet_end(out_packet_end)
  );

endmodule
